FILE: hw/rtl/cfj_pkg.sv
`timescale 1ns / 1ps

package cfj_pkg;

   // Byte codes the scanner reacts to
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   // Quote kinds
   localparam logic [1:0] QK_NONE   = 2'd0;
   localparam logic [1:0] QK_DOUBLE = 2'd1;
   localparam logic [1:0] QK_SINGLE = 2'd2;

   // Configuration register indexes
   localparam logic CSR_DROP_CR      = 1'b0;
   localparam logic CSR_SINGLE_QUOTE = 1'b1;

   // One result item
   typedef struct packed {
      logic       last;
      logic       line_end;
      logic       has_char;
      logic [7:0] ch;
   } rsp_type;

   // Results of one accepted byte, handed from scanner to output queue
   typedef struct packed {
      logic [1:0] count;
      rsp_type    slot1;
      rsp_type    slot0;
   } push_type;

   // Outcome of one byte inside a line or at line start
   typedef struct packed {
      logic [1:0] qk;
      logic       bs;
      logic       to_comment;
      logic       to_pending;
      logic       to_lead_comment;
      logic       to_line;
      logic [1:0] n;
      logic [7:0] c0;
      logic [7:0] c1;
   } lb_type;

   function automatic lb_type line_byte(input logic [7:0] c, input logic [1:0] qk,
                                        input logic bs, input logic icr,
                                        input logic sq_en);
      lb_type r;
      logic   q;
      logic   qmatch;
      r        = '0;
      r.qk     = qk;
      r.bs     = bs;
      q        = (qk != QK_NONE);
      qmatch   = ((qk == QK_DOUBLE) && (c == CH_DQUOTE)) ||
                 ((qk == QK_SINGLE) && (c == CH_SQUOTE));
      if (bs) begin
         // pending escape: resolve it with this byte
         r.bs = 1'b0;
         if (c == CH_HASH) begin
            if (q) begin
               r.n  = 2'd2;
               r.c0 = CH_BSLASH;
               r.c1 = CH_HASH;
            end else begin
               r.n  = 2'd1;
               r.c0 = CH_HASH;
            end
         end else if (c == CH_CR) begin
            if (!icr) begin
               r.n  = 2'd2;
               r.c0 = CH_BSLASH;
               r.c1 = c;
            end
         end else if (c != CH_LF) begin
            r.n  = 2'd2;
            r.c0 = CH_BSLASH;
            r.c1 = c;
         end
      end else if (qmatch) begin
         r.qk = QK_NONE;
         r.n  = 2'd1;
         r.c0 = c;
      end else begin
         case (c)
            CH_HASH: begin
               if (q) begin
                  r.n  = 2'd1;
                  r.c0 = c;
               end else begin
                  r.to_comment = 1'b1;
               end
            end
            CH_CR: begin
               if (q || !icr) begin
                  r.n  = 2'd1;
                  r.c0 = c;
               end
            end
            CH_LF: begin
               if (q) begin
                  r.n  = 2'd1;
                  r.c0 = c;
               end else begin
                  r.to_pending = 1'b1;
               end
            end
            CH_DQUOTE: begin
               if (!q) r.qk = QK_DOUBLE;
               r.n  = 2'd1;
               r.c0 = c;
            end
            CH_SQUOTE: begin
               if (sq_en && !q) r.qk = QK_SINGLE;
               r.n  = 2'd1;
               r.c0 = c;
            end
            CH_BSLASH: begin
               r.bs = 1'b1;
            end
            default: begin
               r.n  = 2'd1;
               r.c0 = c;
            end
         endcase
      end
      return r;
   endfunction

   function automatic lb_type lead_byte(input logic [7:0] c, input logic [1:0] qk,
                                        input logic bs, input logic icr,
                                        input logic sq_en);
      lb_type r;
      r    = '0;
      r.qk = qk;
      r.bs = bs;
      if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (icr && (c == CH_CR))) begin
         r.n = 2'd0;
      end else if (c == CH_HASH) begin
         r.to_lead_comment = 1'b1;
      end else begin
         r         = line_byte(c, QK_NONE, 1'b0, icr, sq_en);
         r.to_line = 1'b1;
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/config_line_joiner.sv
`timescale 1ns / 1ps

// Channel  Direction  tdata            tuser                      tlast
// req_     in         ch[7:0]          -                          -
// rsp_     out        out_char[7:0]    has_char[0], line_end[1]   last_of_run
// csr_     in         csr_data = value, csr_index = register (0 drop CR, 1 single quote)
//
// One byte is taken per cycle while req_tready is high; each byte yields zero, one or two
// result items. The scanner updates its mode registers at the accept edge and drops its
// results into a three-entry output queue; req_tready is high while the queue holds at
// most one item, so single-result bytes stream at one per cycle while the sink takes
// every item. Synchronous active-high reset clears the mode, the queue and both
// configuration bits. csr_ready is always high.

module config_line_joiner (
   input  logic       clock,
   input  logic       reset,
   // input bytes
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] ch
   // result items
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic [1:0] rsp_tuser,   // [0] has_char, [1] line_end
   output logic       rsp_tlast,   // last_of_run
   // configuration writes
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic       csr_data
);

   logic              drop_cr_ff;
   logic              single_quote_ff;
   logic              room;
   logic              accept;
   cfj_pkg::push_type push;
   cfj_pkg::rsp_type  head;

   assign csr_ready  = 1'b1;
   assign req_tready = room;
   assign accept     = req_tvalid && room;

   // hold configuration; the user must make writes only while the block is idle, unenforced here
   always_ff @(posedge clock) begin
      if (reset) begin
         drop_cr_ff      <= 1'b0;
         single_quote_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cfj_pkg::CSR_DROP_CR:      drop_cr_ff      <= csr_data;
            cfj_pkg::CSR_SINGLE_QUOTE: single_quote_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // decode one byte against the current mode, advance the mode on accept
   cfj_scan u_scan (
      .clock               (clock),
      .reset               (reset),
      .accept              (accept),
      .ch                  (req_tdata),
      .drop_cr             (drop_cr_ff),
      .single_quote_enable (single_quote_ff),
      .push                (push)
   );

   // buffer results so input is taken while the queue holds at most one item, even if the sink stalls
   cfj_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .head_valid (rsp_tvalid),
      .head_ready (rsp_tready),
      .head       (head)
   );

   assign rsp_tdata = head.ch;
   assign rsp_tuser = {head.line_end, head.has_char};
   assign rsp_tlast = head.last;

endmodule

FILE: hw/rtl/cfj_scan.sv
`timescale 1ns / 1ps

module cfj_scan (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        ch,
   input  logic              drop_cr,
   input  logic              single_quote_enable,
   output cfj_pkg::push_type push
);

   typedef enum logic [2:0] {
      MODE_LEAD         = 3'd0,
      MODE_LEAD_COMMENT = 3'd1,
      MODE_LINE         = 3'd2,
      MODE_COMMENT      = 3'd3,
      MODE_PENDING      = 3'd4
   } mode_type;

   mode_type        mode_ff, mode_in;
   logic [1:0]      qk_ff, qk_in;
   logic            bs_ff, bs_in;
   logic            ne_ff, ne_in;

   cfj_pkg::lb_type  lb;
   cfj_pkg::rsp_type slot [2];
   logic             pre_end, post_end, ne_clear, use_lb, ne_tmp;
   logic [1:0]       k;
   mode_type         base_mode;

   always_comb begin
      mode_in   = mode_ff;
      qk_in     = qk_ff;
      bs_in     = bs_ff;
      lb        = '0;
      use_lb    = 1'b0;
      pre_end   = 1'b0;
      post_end  = 1'b0;
      ne_clear  = 1'b0;
      base_mode = mode_ff;

      if (ch == cfj_pkg::CH_NUL) begin
         // end of text: flush a dangling backslash, close the line, clear all
         if ((mode_ff == MODE_LINE) && bs_ff) begin
            lb.n  = 2'd1;
            lb.c0 = cfj_pkg::CH_BSLASH;
         end
         post_end = 1'b1;
         mode_in  = MODE_LEAD;
         qk_in    = cfj_pkg::QK_NONE;
         bs_in    = 1'b0;
      end else begin
         case (mode_ff)
            MODE_LEAD_COMMENT: begin
               if (ch == cfj_pkg::CH_LF) mode_in = MODE_LEAD;
            end
            MODE_LINE: begin
               lb        = cfj_pkg::line_byte(ch, qk_ff, bs_ff, drop_cr, single_quote_enable);
               use_lb    = 1'b1;
               base_mode = MODE_LINE;
            end
            MODE_COMMENT: begin
               if (ch == cfj_pkg::CH_LF) begin
                  if (bs_ff) begin
                     bs_in   = 1'b0;
                     mode_in = MODE_LINE;
                  end else begin
                     pre_end = 1'b1;
                     mode_in = MODE_LEAD;
                     qk_in   = cfj_pkg::QK_NONE;
                  end
               end else begin
                  bs_in = (ch == cfj_pkg::CH_BSLASH);
               end
            end
            MODE_PENDING: begin
               if ((ch == cfj_pkg::CH_SPACE) || (ch == cfj_pkg::CH_TAB)) begin
                  mode_in = MODE_LINE;
                  lb.n    = 2'd1;
                  lb.c0   = ch;
               end else begin
                  pre_end   = 1'b1;
                  lb        = cfj_pkg::lead_byte(ch, cfj_pkg::QK_NONE, 1'b0, drop_cr,
                                                 single_quote_enable);
                  use_lb    = 1'b1;
                  base_mode = MODE_LEAD;
               end
            end
            MODE_LEAD: begin
               lb        = cfj_pkg::lead_byte(ch, qk_ff, bs_ff, drop_cr, single_quote_enable);
               use_lb    = 1'b1;
               base_mode = MODE_LEAD;
            end
            default: begin
               ne_clear  = 1'b1;
               lb        = cfj_pkg::lead_byte(ch, cfj_pkg::QK_NONE, 1'b0, drop_cr,
                                              single_quote_enable);
               use_lb    = 1'b1;
               base_mode = MODE_LEAD;
            end
         endcase
      end

      if (use_lb) begin
         qk_in = lb.qk;
         bs_in = lb.bs;
         if (lb.to_comment)           mode_in = MODE_COMMENT;
         else if (lb.to_pending)      mode_in = MODE_PENDING;
         else if (lb.to_lead_comment) mode_in = MODE_LEAD_COMMENT;
         else if (lb.to_line)         mode_in = MODE_LINE;
         else                         mode_in = base_mode;
      end

      // assemble results: optional close, up to two bytes, optional close
      slot[0] = '0;
      slot[1] = '0;
      k       = 2'd0;
      ne_tmp  = ne_clear ? 1'b0 : ne_ff;
      if (pre_end) begin
         if (ne_tmp && (k < 2'd2)) begin
            slot[k[0]].line_end = 1'b1;
            k = k + 2'd1;
         end
         ne_tmp = 1'b0;
      end
      for (int j = 0; j < 2; j++) begin
         if ((2'(j) < lb.n) && (k < 2'd2)) begin
            slot[k[0]].has_char = 1'b1;
            slot[k[0]].ch       = (j == 0) ? lb.c0 : lb.c1;
            k      = k + 2'd1;
            ne_tmp = 1'b1;
         end
      end
      if (post_end) begin
         if (ne_tmp && (k < 2'd2)) begin
            slot[k[0]].line_end = 1'b1;
            k = k + 2'd1;
         end
         ne_tmp = 1'b0;
      end
      if (k != 2'd0) slot[k[0] ^ 1'b1].last = 1'b1;
      ne_in = ne_tmp;

      push.count = accept ? k : 2'd0;
      push.slot0 = slot[0];
      push.slot1 = slot[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LEAD;
         qk_ff   <= cfj_pkg::QK_NONE;
         bs_ff   <= 1'b0;
         ne_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         qk_ff   <= qk_in;
         bs_ff   <= bs_in;
         ne_ff   <= ne_in;
      end
   end

endmodule

FILE: hw/rtl/cfj_rsp_queue.sv
`timescale 1ns / 1ps

module cfj_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  cfj_pkg::push_type push,
   output logic              room,
   output logic              head_valid,
   input  logic              head_ready,
   output cfj_pkg::rsp_type  head
);

   cfj_pkg::rsp_type entry_ff [3];
   cfj_pkg::rsp_type entry_in [3];
   logic [1:0]       count_ff, count_in;
   logic [1:0]       base;
   logic             pop;

   assign head_valid = (count_ff != 2'd0);
   assign head       = entry_ff[0];
   // room for two more results whatever the sink does
   assign room       = !count_ff[1];
   assign pop        = head_valid && head_ready;

   always_comb begin
      base = count_ff - {1'b0, pop};
      for (int i = 0; i < 3; i++) begin
         if (pop && (i < 2)) entry_in[i] = entry_ff[i + 1];
         else                entry_in[i] = entry_ff[i];
         if ((push.count != 2'd0) && (2'(i) == base))        entry_in[i] = push.slot0;
         if ((push.count == 2'd2) && (2'(i) == base + 2'd1)) entry_in[i] = push.slot1;
      end
      count_in = base + push.count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      for (int i = 0; i < 3; i++) entry_ff[i] <= entry_in[i];
   end

endmodule

FILE: hw/rtl/cfj_checker.sv
`timescale 1ns / 1ps

module cfj_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   // a stalled result holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // every result is either a line byte or a line close, never both or neither
   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] != rsp_tuser[1]))
      else $error("result is neither a byte nor a line close");

   // input back-pressure only while results are queued
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty output");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind config_line_joiner cfj_checker u_cfj_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

FILE: tb/tb_config_line_joiner.sv
`timescale 1ns / 1ps

// Self-checking bench for config_line_joiner.
// Text bytes go in on req_, joined line items come back on rsp_. A bench-side
// line joiner predicts the items of every accepted byte, and the monitor
// compares each returned item against the oldest prediction.

module tb_config_line_joiner;

   // Scanner modes of the bench-side line joiner
   typedef enum logic [2:0] {
      SKIP_LEAD,
      SKIP_COMMENT,
      IN_LINE,
      IN_COMMENT,
      NL_PENDING
   } scan_mode_type;

   // One expected result item
   typedef struct packed {
      logic [7:0] ch;
      logic       has_char;
      logic       line_end;
      logic       last;
   } line_item_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;
   logic       csr_valid  = 1'b0;
   logic       csr_ready;
   logic       csr_index  = 1'b0;
   logic       csr_data   = 1'b0;

   config_line_joiner dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // Bytes waiting to be sent, and line items the block still owes us
   logic [7:0] text_bytes[$];
   line_item_type expected_items[$];
   line_item_type step_items[$];

   // Bench-side joiner state and its copy of the configuration
   scan_mode_type scan_state  = SKIP_LEAD;
   logic [1:0] quote_now      = cfj_pkg::QK_NONE;
   logic       escape_held    = 1'b0;
   logic       line_has_text  = 1'b0;
   logic       cfg_drop_cr    = 1'b0;
   logic       cfg_single_q   = 1'b0;

   // Traffic shaping
   bit steady     = 1'b0;   // no sender gaps, receiver always ready
   int gap_left   = 0;
   int burst_left = 0;
   int fails      = 0;
   int queued     = 0;

   // ------------------------------------------------------------------
   // Line joiner prediction
   // ------------------------------------------------------------------
   function automatic void put_byte(input logic [7:0] c);
      line_item_type it;
      it          = '0;
      it.ch       = c;
      it.has_char = 1'b1;
      step_items.push_back(it);
      line_has_text = 1'b1;
   endfunction

   // Close the logical line, but only if something of it was emitted
   function automatic void close_line();
      line_item_type it;
      it = '0;
      if (line_has_text) begin
         it.line_end = 1'b1;
         step_items.push_back(it);
      end
      line_has_text = 1'b0;
   endfunction

   function automatic void reset_scan();
      scan_state    = SKIP_LEAD;
      quote_now     = cfj_pkg::QK_NONE;
      escape_held   = 1'b0;
      line_has_text = 1'b0;
   endfunction

   function automatic void in_line_byte(input logic [7:0] c);
      logic quoted;
      logic closes;
      quoted = (quote_now != cfj_pkg::QK_NONE);
      closes = ((quote_now == cfj_pkg::QK_DOUBLE) && (c == cfj_pkg::CH_DQUOTE)) ||
               ((quote_now == cfj_pkg::QK_SINGLE) && (c == cfj_pkg::CH_SQUOTE));
      if (escape_held) begin
         // resolve the pending backslash with this byte
         escape_held = 1'b0;
         if (c == cfj_pkg::CH_HASH) begin
            if (quoted) put_byte(cfj_pkg::CH_BSLASH);
            put_byte(cfj_pkg::CH_HASH);
         end else if (c == cfj_pkg::CH_CR) begin
            if (!cfg_drop_cr) begin
               put_byte(cfj_pkg::CH_BSLASH);
               put_byte(c);
            end
         end else if (c != cfj_pkg::CH_LF) begin
            put_byte(cfj_pkg::CH_BSLASH);
            put_byte(c);
         end
      end else if (closes) begin
         quote_now = cfj_pkg::QK_NONE;
         put_byte(c);
      end else begin
         case (c)
            cfj_pkg::CH_HASH: begin
               if (quoted) begin
                  put_byte(c);
               end else begin
                  scan_state  = IN_COMMENT;
                  escape_held = 1'b0;
               end
            end
            cfj_pkg::CH_CR: begin
               if (quoted || !cfg_drop_cr) put_byte(c);
            end
            cfj_pkg::CH_LF: begin
               if (quoted) put_byte(c);
               else scan_state = NL_PENDING;
            end
            cfj_pkg::CH_DQUOTE: begin
               if (!quoted) quote_now = cfj_pkg::QK_DOUBLE;
               put_byte(c);
            end
            cfj_pkg::CH_SQUOTE: begin
               if (cfg_single_q && !quoted) quote_now = cfj_pkg::QK_SINGLE;
               put_byte(c);
            end
            cfj_pkg::CH_BSLASH: begin
               escape_held = 1'b1;
            end
            default: begin
               put_byte(c);
            end
         endcase
      end
   endfunction

   // First byte that could start a line: blanks and comments are skipped
   function automatic void start_byte(input logic [7:0] c);
      if (c == cfj_pkg::CH_SPACE || c == cfj_pkg::CH_TAB || c == cfj_pkg::CH_LF ||
          (cfg_drop_cr && c == cfj_pkg::CH_CR)) begin
         return;
      end
      if (c == cfj_pkg::CH_HASH) begin
         scan_state = SKIP_COMMENT;
         return;
      end
      scan_state  = IN_LINE;
      quote_now   = cfj_pkg::QK_NONE;
      escape_held = 1'b0;
      in_line_byte(c);
   endfunction

   // Predict the items of one accepted byte and queue them
   function automatic void join_byte(input logic [7:0] c);
      step_items.delete();
      if (c == cfj_pkg::CH_NUL) begin
         // end of text: flush a dangling backslash, close the line, start over
         if (scan_state == IN_LINE && escape_held) put_byte(cfj_pkg::CH_BSLASH);
         close_line();
         reset_scan();
      end else begin
         case (scan_state)
            SKIP_COMMENT: begin
               if (c == cfj_pkg::CH_LF) scan_state = SKIP_LEAD;
            end
            IN_LINE: begin
               in_line_byte(c);
            end
            IN_COMMENT: begin
               if (c == cfj_pkg::CH_LF) begin
                  if (escape_held) begin
                     // comment ended in backslash: the line goes on
                     escape_held = 1'b0;
                     scan_state  = IN_LINE;
                  end else begin
                     close_line();
                     scan_state = SKIP_LEAD;
                     quote_now  = cfj_pkg::QK_NONE;
                  end
               end else begin
                  escape_held = (c == cfj_pkg::CH_BSLASH);
               end
            end
            NL_PENDING: begin
               if (c == cfj_pkg::CH_SPACE || c == cfj_pkg::CH_TAB) begin
                  scan_state = IN_LINE;
                  put_byte(c);
               end else begin
                  close_line();
                  scan_state  = SKIP_LEAD;
                  quote_now   = cfj_pkg::QK_NONE;
                  escape_held = 1'b0;
                  start_byte(c);
               end
            end
            default: begin
               start_byte(c);
            end
         endcase
      end
      if (step_items.size() > 0) step_items[step_items.size() - 1].last = 1'b1;
      foreach (step_items[i]) expected_items.push_back(step_items[i]);
   endfunction

   // ------------------------------------------------------------------
   // Driver: send queued bytes in bursts, predict on every accept
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) join_byte(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 || text_bytes.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               req_tdata  <= text_bytes.pop_front();
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // burst over: draw the next burst and the gap before it
                  burst_left = $urandom_range(0, 24);
                  if (steady || $urandom_range(0, 2) == 0) gap_left = 0;
                  else gap_left = $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: stall on a rotating ready mask, check every accepted item
   // ------------------------------------------------------------------
   int          cyc        = 0;
   logic [11:0] ready_mask = '1;

   task automatic report(input string msg);
      fails++;
      if (fails <= 10) $display("%t mismatch: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      line_item_type exp_item;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_items.size() == 0) begin
            report($sformatf("unexpected item ch=%h user=%b last=%b",
                             rsp_tdata, rsp_tuser, rsp_tlast));
         end else begin
            exp_item = expected_items.pop_front();
            if (rsp_tdata !== exp_item.ch || rsp_tuser[0] !== exp_item.has_char ||
                rsp_tuser[1] !== exp_item.line_end || rsp_tlast !== exp_item.last) begin
               report($sformatf({"exp ch=%h has=%b end=%b last=%b, ",
                                 "got ch=%h has=%b end=%b last=%b"},
                                exp_item.ch, exp_item.has_char, exp_item.line_end,
                                exp_item.last, rsp_tdata, rsp_tuser[0], rsp_tuser[1],
                                rsp_tlast));
            end
         end
      end
      // redraw the stall pattern now and then; bit 0 keeps it from locking up
      cyc++;
      if (cyc % 300 == 0) begin
         case ($urandom_range(0, 3))
            0:       ready_mask = '1;
            1:       ready_mask = 12'h001;
            default: ready_mask = 12'($urandom) | 12'h001;
         endcase
      end
      rsp_tready <= steady ? 1'b1 : ready_mask[cyc % 12];
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   task automatic add_byte(input logic [7:0] c);
      text_bytes.push_back(c);
      queued++;
   endtask

   function automatic logic [7:0] printable();
      return 8'($urandom_range(8'h21, 8'h7e));
   endfunction

   // Any nonzero byte with the characters the scanner reacts to favored
   function automatic logic [7:0] any_byte();
      case ($urandom_range(0, 11))
         0:       return cfj_pkg::CH_HASH;
         1:       return cfj_pkg::CH_BSLASH;
         2:       return cfj_pkg::CH_DQUOTE;
         3:       return cfj_pkg::CH_SQUOTE;
         4:       return cfj_pkg::CH_CR;
         5:       return cfj_pkg::CH_LF;
         6:       return cfj_pkg::CH_TAB;
         7:       return cfj_pkg::CH_SPACE;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   // One fragment of configuration-like text
   task automatic add_chunk();
      logic [7:0] q;
      int n;
      case ($urandom_range(0, 13))
         0, 1, 2, 3: begin
            n = $urandom_range(1, 6);
            repeat (n) add_byte(printable());
         end
         4, 5: begin
            q = $urandom_range(0, 1) ? cfj_pkg::CH_DQUOTE : cfj_pkg::CH_SQUOTE;
            add_byte(q);
            n = $urandom_range(0, 5);
            repeat (n) add_byte(any_byte());
            if ($urandom_range(0, 5) != 0) add_byte(q);
         end
         6: begin
            add_byte(cfj_pkg::CH_HASH);
            n = $urandom_range(0, 4);
            repeat (n) add_byte($urandom_range(0, 3) == 0 ? any_byte() : printable());
            if ($urandom_range(0, 1)) add_byte(cfj_pkg::CH_BSLASH);
            add_byte(cfj_pkg::CH_LF);
         end
         7: begin
            add_byte(cfj_pkg::CH_BSLASH);
            case ($urandom_range(0, 3))
               0:       add_byte(cfj_pkg::CH_HASH);
               1:       add_byte(cfj_pkg::CH_LF);
               2:       add_byte(cfj_pkg::CH_CR);
               default: add_byte(any_byte());
            endcase
         end
         8, 9: begin
            add_byte(cfj_pkg::CH_LF);
            case ($urandom_range(0, 3))
               0:       add_byte(cfj_pkg::CH_SPACE);
               1:       add_byte(cfj_pkg::CH_TAB);
               default: ;
            endcase
         end
         10: begin
            n = $urandom_range(1, 3);
            repeat (n) add_byte($urandom_range(0, 2) == 0 ? cfj_pkg::CH_TAB :
                                $urandom_range(0, 1) ? cfj_pkg::CH_SPACE : cfj_pkg::CH_CR);
         end
         11: begin
            add_byte(cfj_pkg::CH_CR);
            add_byte(cfj_pkg::CH_LF);
         end
         12: begin
            add_byte(8'($urandom_range(1, 255)));
         end
         default: begin
            // end of text now and then, otherwise just a newline
            add_byte($urandom_range(0, 3) == 0 ? cfj_pkg::CH_NUL : cfj_pkg::CH_LF);
         end
      endcase
   endtask

   task automatic write_reg(input logic idx, input logic val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == cfj_pkg::CSR_DROP_CR) cfg_drop_cr = val;
      else cfg_single_q = val;
   endtask

   // Hold until every byte is in and every predicted item is out, then let the
   // block settle past bytes that produce nothing
   task automatic drain();
      while (text_bytes.size() != 0 || req_tvalid || expected_items.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   logic [7:0] directed[] = '{
      // leading comment, no continuation
      cfj_pkg::CH_SPACE, cfj_pkg::CH_HASH, cfj_pkg::CH_BSLASH, cfj_pkg::CH_LF,
      // escaped hash outside quotes
      "a", cfj_pkg::CH_BSLASH, cfj_pkg::CH_HASH,
      // hash and escaped newline in quotes
      cfj_pkg::CH_DQUOTE, cfj_pkg::CH_HASH, cfj_pkg::CH_BSLASH, cfj_pkg::CH_LF,
      // kept CR, newline joined by tab
      cfj_pkg::CH_DQUOTE, cfj_pkg::CH_CR, cfj_pkg::CH_LF, cfj_pkg::CH_TAB,
      // comment ending in backslash
      cfj_pkg::CH_HASH, cfj_pkg::CH_BSLASH, cfj_pkg::CH_LF,
      // line close, dangling backslash at end
      8'hff, cfj_pkg::CH_LF, "b", cfj_pkg::CH_BSLASH, cfj_pkg::CH_NUL,
      // end of text with newline pending
      8'h01, cfj_pkg::CH_LF, cfj_pkg::CH_NUL
   };

   initial begin
      int target;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part at reset configuration
      foreach (directed[i]) add_byte(directed[i]);
      drain();

      // random phases over every setting of the two registers
      target = 0;
      for (int p = 1; p <= 5; p++) begin
         write_reg(cfj_pkg::CSR_DROP_CR, p[0]);
         write_reg(cfj_pkg::CSR_SINGLE_QUOTE, p[1]);
         steady = (p == 3);
         target += 350;
         while (queued < target) add_chunk();
         add_byte(cfj_pkg::CH_NUL);
         drain();
      end

      if (fails == 0 && expected_items.size() == 0) begin
         $display("PASS config_line_joiner");
      end else begin
         $display("FAIL config_line_joiner");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5ms;
      $display("FAIL config_line_joiner");
      $finish;
   end

endmodule
